### hw/rtl/wfra_pkg.sv
`timescale 1ns / 1ps
// Shared widths, status codes and request codes of the worst-fit region allocator.
package wfra_pkg;

  localparam int unsigned REQ_BYTES_W    = 21;
  localparam int unsigned OFFSET_W       = 20;
  localparam int unsigned STATUS_W       = 3;
  localparam int unsigned REGION_PAGES_W = 9;
  localparam int unsigned HEADER_BYTES   = 8;
  localparam int unsigned NODE_BYTES     = 16;
  localparam int unsigned AVAIL_MAX      = 32'h000F_FFFF;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_SIZE = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd4;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

endpackage

### hw/rtl/wfra_req_if.sv
`timescale 1ns / 1ps
// Request channel interface of the worst-fit region allocator.
interface wfra_req_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic [wfra_pkg::REQ_BYTES_W-1:0]    request_bytes;
  logic [wfra_pkg::OFFSET_W-1:0]       free_offset;

  modport source (output valid, req_type, request_bytes, free_offset, input ready);
  modport sink   (input valid, req_type, request_bytes, free_offset, output ready);
endinterface

### hw/rtl/wfra_rsp_if.sv
`timescale 1ns / 1ps
// Response channel interface of the worst-fit region allocator.
interface wfra_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [wfra_pkg::STATUS_W-1:0]    status;
  logic [wfra_pkg::OFFSET_W-1:0]    user_offset;
  logic [wfra_pkg::OFFSET_W-1:0]    available_bytes;

  modport source (output valid, status, user_offset, available_bytes, input ready);
  modport sink   (input valid, status, user_offset, available_bytes, output ready);
endinterface

### hw/rtl/wfra_mem.sv
`timescale 1ns / 1ps
// Single write port, single read port table memory with registered read data.
module wfra_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 42
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/worst_fit_region_allocator.sv
`timescale 1ns / 1ps
// Worst-fit region allocator: free-extent table, live-block table and request sequencer.
//
// Requests arrive on the req channel as valid/ready transactions: an allocation asks for
// request_bytes, a free returns a user offset. Each request produces exactly one response
// transaction on the rsp channel with a status, the granted user offset and the free byte
// count left, unless a configuration write interrupts it. The configuration write port sets
// the region size in pages; a write reloads the tables before the next request is taken.
// Requests are handled one at a time by a sequencer that walks the tables through the read
// ports of the free-table and live-table memories. An allocation scans the live valid bits,
// then the free table, may shift the free table down by one entry, then sums the free table.
// A free scans the live table, locates the insert point, shifts entries up or down, and sums.
// After reset the block first loads the full region as a single free extent.
// The response is held in an output register; if the receiver stalls, the next request may
// already be taken, and its result waits until the previous response has been accepted.
module worst_fit_region_allocator #(
  parameter int unsigned PAGE_BYTES      = 4096,
  parameter int unsigned MAX_PAGES       = 256,
  parameter int unsigned MAX_LIVE_BLOCKS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [wfra_pkg::REGION_PAGES_W-1:0]  cfg_wdata_i,
  wfra_req_if.sink                             req,
  wfra_rsp_if.source                           rsp
);

  localparam int unsigned FD   = MAX_LIVE_BLOCKS + 1;
  localparam int unsigned FIW  = $clog2(FD);
  localparam int unsigned FCW  = $clog2(FD + 1);
  localparam int unsigned LIW  = $clog2(MAX_LIVE_BLOCKS);
  localparam int unsigned LW   = $clog2(MAX_PAGES * PAGE_BYTES + 1);
  localparam int unsigned XW   = ((LW > 21) ? LW : 21) + 2;
  localparam int unsigned SUMW = LW + FCW;
  localparam int unsigned RW   = $clog2(MAX_PAGES + 1);
  localparam int unsigned RESET_PAGES = (MAX_PAGES < 256) ? MAX_PAGES : 256;

  localparam logic [4:0] S_INIT    = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_SLOT    = 5'd2;
  localparam logic [4:0] S_BEST_RD = 5'd3;
  localparam logic [4:0] S_BEST_EV = 5'd4;
  localparam logic [4:0] S_GRANT   = 5'd5;
  localparam logic [4:0] S_LOOK_RD = 5'd6;
  localparam logic [4:0] S_LOOK_EV = 5'd7;
  localparam logic [4:0] S_POS_RD  = 5'd8;
  localparam logic [4:0] S_POS_EV  = 5'd9;
  localparam logic [4:0] S_PLACE   = 5'd10;
  localparam logic [4:0] S_SHU_RD  = 5'd11;
  localparam logic [4:0] S_SHU_WR  = 5'd12;
  localparam logic [4:0] S_MNEXT   = 5'd13;
  localparam logic [4:0] S_SHD_RD  = 5'd14;
  localparam logic [4:0] S_SHD_WR  = 5'd15;
  localparam logic [4:0] S_SUM_RD  = 5'd16;
  localparam logic [4:0] S_SUM_EV  = 5'd17;
  localparam logic [4:0] S_DONE    = 5'd18;

  logic [4:0]                      state_q, state_d;
  logic [RW-1:0]                   region_q, region_d;
  logic [FCW-1:0]                  fcnt_q, fcnt_d;
  logic [FCW-1:0]                  i_q, i_d;
  logic [LIW:0]                    li_q, li_d;
  logic [FCW-1:0]                  pos_q, pos_d;
  logic [LIW-1:0]                  slot_q, slot_d;
  logic [MAX_LIVE_BLOCKS-1:0]      lvalid_q, lvalid_d;
  logic [XW-1:0]                   need_q, need_d;
  logic [XW-1:0]                   start_q, start_d;
  logic [LW-1:0]                   len_q, len_d;
  logic [LW-1:0]                   best_s_q, best_s_d, best_l_q, best_l_d;
  logic [FCW-1:0]                  best_i_q, best_i_d;
  logic [LW-1:0]                   prev_s_q, prev_s_d, prev_l_q, prev_l_d;
  logic [LW-1:0]                   next_s_q, next_s_d, next_l_q, next_l_d;
  logic [LW-1:0]                   cur_s_q, cur_s_d, cur_l_q, cur_l_d;
  logic [SUMW-1:0]                 acc_q, acc_d;
  logic [wfra_pkg::STATUS_W-1:0]   status_q, status_d;
  logic [wfra_pkg::OFFSET_W-1:0]   user_q, user_d;
  logic                            rsp_valid_q, rsp_valid_d;
  logic [wfra_pkg::STATUS_W-1:0]   rsp_status_q, rsp_status_d;
  logic [wfra_pkg::OFFSET_W-1:0]   rsp_user_q, rsp_user_d;
  logic [wfra_pkg::OFFSET_W-1:0]   rsp_avail_q, rsp_avail_d;

  logic                  f_we;
  logic [FIW-1:0]        f_waddr, f_raddr;
  logic [2*LW-1:0]       f_wdata, f_rdata;
  logic                  l_we;
  logic [LIW-1:0]        l_waddr, l_raddr;
  logic [2*LW-1:0]       l_wdata, l_rdata;
  logic [LW-1:0]         fr_s, fr_l, lr_s, lr_l;
  logic [LW-1:0]         region_bytes;
  logic [LIW-1:0]        li_idx;

  assign fr_s         = f_rdata[2*LW-1:LW];
  assign fr_l         = f_rdata[LW-1:0];
  assign lr_s         = l_rdata[2*LW-1:LW];
  assign lr_l         = l_rdata[LW-1:0];
  assign region_bytes = LW'(32'(region_q) * PAGE_BYTES);
  assign li_idx       = li_q[LIW-1:0];

  wfra_mem #(.DEPTH(FD), .WIDTH(2 * LW)) u_free_mem (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  wfra_mem #(.DEPTH(MAX_LIVE_BLOCKS), .WIDTH(2 * LW)) u_live_mem (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  always_comb begin
    state_d     = state_q;
    region_d    = region_q;
    fcnt_d      = fcnt_q;
    i_d         = i_q;
    li_d        = li_q;
    pos_d       = pos_q;
    slot_d      = slot_q;
    lvalid_d    = lvalid_q;
    need_d      = need_q;
    start_d     = start_q;
    len_d       = len_q;
    best_s_d    = best_s_q;
    best_l_d    = best_l_q;
    best_i_d    = best_i_q;
    prev_s_d    = prev_s_q;
    prev_l_d    = prev_l_q;
    next_s_d    = next_s_q;
    next_l_d    = next_l_q;
    cur_s_d     = cur_s_q;
    cur_l_d     = cur_l_q;
    acc_d       = acc_q;
    status_d    = status_q;
    user_d      = user_q;
    rsp_valid_d = rsp_valid_q && !rsp.ready;
    rsp_status_d = rsp_status_q;
    rsp_user_d  = rsp_user_q;
    rsp_avail_d = rsp_avail_q;
    f_we        = 1'b0;
    f_waddr     = '0;
    f_wdata     = '0;
    f_raddr     = '0;
    l_we        = 1'b0;
    l_waddr     = '0;
    l_wdata     = '0;
    l_raddr     = '0;
    req.ready   = 1'b0;

    case (state_q)
      S_INIT: begin
        f_we     = 1'b1;
        f_wdata  = {LW'(0), region_bytes};
        fcnt_d   = FCW'(1);
        lvalid_d = '0;
        state_d  = S_IDLE;
      end
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          status_d = wfra_pkg::STATUS_OK;
          user_d   = '0;
          i_d      = '0;
          li_d     = '0;
          acc_d    = '0;
          if (req.req_type == wfra_pkg::REQ_FREE) begin
            start_d = XW'(req.free_offset) - XW'(wfra_pkg::HEADER_BYTES);
            if (req.free_offset[2:0] != 3'd0 ||
                32'(req.free_offset) < wfra_pkg::HEADER_BYTES) begin
              status_d = wfra_pkg::STATUS_BAD_ADDR;
              state_d  = S_SUM_RD;
            end else begin
              state_d = S_LOOK_RD;
            end
          end else begin
            need_d = ((XW'(req.request_bytes) + XW'(7)) & ~XW'(7)) +
                     XW'(wfra_pkg::HEADER_BYTES);
            if (req.request_bytes == '0) begin
              status_d = wfra_pkg::STATUS_BAD_SIZE;
              state_d  = S_SUM_RD;
            end else begin
              state_d = S_SLOT;
            end
          end
        end
      end
      S_SLOT: begin
        if (!lvalid_q[li_idx]) begin
          slot_d   = li_idx;
          best_l_d = '0;
          best_i_d = '0;
          state_d  = S_BEST_RD;
        end else if (li_q == (LIW+1)'(MAX_LIVE_BLOCKS - 1)) begin
          status_d = wfra_pkg::STATUS_FULL;
          state_d  = S_SUM_RD;
        end else begin
          li_d = li_q + 1'b1;
        end
      end
      S_BEST_RD: begin
        f_raddr = i_q[FIW-1:0];
        state_d = (i_q == fcnt_q) ? S_GRANT : S_BEST_EV;
      end
      S_BEST_EV: begin
        if (i_q == '0 || fr_l > best_l_q) begin
          best_s_d = fr_s;
          best_l_d = fr_l;
          best_i_d = i_q;
        end
        i_d     = i_q + 1'b1;
        state_d = S_BEST_RD;
      end
      S_GRANT: begin
        i_d = '0;
        if (fcnt_q == '0 || XW'(best_l_q) < need_q) begin
          status_d = wfra_pkg::STATUS_NO_SPACE;
          state_d  = S_SUM_RD;
        end else begin
          l_we             = 1'b1;
          l_waddr          = slot_q;
          lvalid_d[slot_q] = 1'b1;
          user_d = wfra_pkg::OFFSET_W'(XW'(best_s_q) + XW'(wfra_pkg::HEADER_BYTES));
          if (XW'(best_l_q) <= need_q + XW'(wfra_pkg::NODE_BYTES)) begin
            l_wdata = {best_s_q, best_l_q};
            i_d     = best_i_q;
            state_d = S_SHD_RD;
          end else begin
            l_wdata = {best_s_q, LW'(need_q)};
            f_we    = 1'b1;
            f_waddr = best_i_q[FIW-1:0];
            f_wdata = {best_s_q + LW'(need_q), best_l_q - LW'(need_q)};
            state_d = S_SUM_RD;
          end
        end
      end
      S_LOOK_RD: begin
        l_raddr = li_idx;
        state_d = S_LOOK_EV;
      end
      S_LOOK_EV: begin
        if (lvalid_q[li_idx] && XW'(lr_s) == start_q) begin
          slot_d           = li_idx;
          len_d            = lr_l;
          lvalid_d[li_idx] = 1'b0;
          i_d              = '0;
          state_d          = S_POS_RD;
        end else if (li_q == (LIW+1)'(MAX_LIVE_BLOCKS - 1)) begin
          status_d = wfra_pkg::STATUS_BAD_ADDR;
          i_d      = '0;
          state_d  = S_SUM_RD;
        end else begin
          li_d    = li_q + 1'b1;
          state_d = S_LOOK_RD;
        end
      end
      S_POS_RD: begin
        f_raddr = i_q[FIW-1:0];
        if (i_q == fcnt_q) begin
          pos_d   = i_q;
          state_d = S_PLACE;
        end else begin
          state_d = S_POS_EV;
        end
      end
      S_POS_EV: begin
        if (XW'(fr_s) < start_q) begin
          prev_s_d = fr_s;
          prev_l_d = fr_l;
          i_d      = i_q + 1'b1;
          state_d  = S_POS_RD;
        end else begin
          pos_d    = i_q;
          next_s_d = fr_s;
          next_l_d = fr_l;
          state_d  = S_PLACE;
        end
      end
      S_PLACE: begin
        if (pos_q != '0 && XW'(prev_s_q) + XW'(prev_l_q) == start_q) begin
          pos_d   = pos_q - 1'b1;
          cur_s_d = prev_s_q;
          cur_l_d = prev_l_q + len_q;
          f_we    = 1'b1;
          f_waddr = FIW'(pos_q - 1'b1);
          f_wdata = {prev_s_q, prev_l_q + len_q};
          state_d = S_MNEXT;
        end else if (32'(fcnt_q) >= FD) begin
          i_d     = '0;
          state_d = S_SUM_RD;
        end else begin
          i_d     = fcnt_q;
          state_d = S_SHU_RD;
        end
      end
      S_SHU_RD: begin
        f_raddr = FIW'(i_q - 1'b1);
        if (i_q == pos_q) begin
          f_we    = 1'b1;
          f_waddr = pos_q[FIW-1:0];
          f_wdata = {LW'(start_q), len_q};
          cur_s_d = LW'(start_q);
          cur_l_d = len_q;
          fcnt_d  = fcnt_q + 1'b1;
          state_d = S_MNEXT;
        end else begin
          state_d = S_SHU_WR;
        end
      end
      S_SHU_WR: begin
        f_we    = 1'b1;
        f_waddr = i_q[FIW-1:0];
        f_wdata = f_rdata;
        i_d     = i_q - 1'b1;
        state_d = S_SHU_RD;
      end
      S_MNEXT: begin
        if ((FCW+1)'(pos_q) + 1'b1 < (FCW+1)'(fcnt_q) &&
            XW'(cur_s_q) + XW'(cur_l_q) == XW'(next_s_q)) begin
          f_we    = 1'b1;
          f_waddr = pos_q[FIW-1:0];
          f_wdata = {cur_s_q, cur_l_q + next_l_q};
          i_d     = pos_q + 1'b1;
          state_d = S_SHD_RD;
        end else begin
          i_d     = '0;
          state_d = S_SUM_RD;
        end
      end
      S_SHD_RD: begin
        f_raddr = FIW'(i_q + 1'b1);
        if ((FCW+1)'(i_q) + 1'b1 < (FCW+1)'(fcnt_q)) begin
          state_d = S_SHD_WR;
        end else begin
          fcnt_d  = fcnt_q - 1'b1;
          i_d     = '0;
          state_d = S_SUM_RD;
        end
      end
      S_SHD_WR: begin
        f_we    = 1'b1;
        f_waddr = i_q[FIW-1:0];
        f_wdata = f_rdata;
        i_d     = i_q + 1'b1;
        state_d = S_SHD_RD;
      end
      S_SUM_RD: begin
        f_raddr = i_q[FIW-1:0];
        state_d = (i_q == fcnt_q) ? S_DONE : S_SUM_EV;
      end
      S_SUM_EV: begin
        if (32'(fr_l) > wfra_pkg::NODE_BYTES) begin
          acc_d = acc_q + SUMW'(fr_l - LW'(wfra_pkg::NODE_BYTES));
        end
        i_d     = i_q + 1'b1;
        state_d = S_SUM_RD;
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = status_q;
          rsp_user_d   = (status_q == wfra_pkg::STATUS_OK) ? user_q : '0;
          rsp_avail_d  = (32'(acc_q) > wfra_pkg::AVAIL_MAX) ?
                         wfra_pkg::OFFSET_W'(wfra_pkg::AVAIL_MAX) :
                         wfra_pkg::OFFSET_W'(acc_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase

    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        region_d = RW'(1);
      end else if (32'(cfg_wdata_i) > MAX_PAGES) begin
        region_d = RW'(MAX_PAGES);
      end else begin
        region_d = RW'(cfg_wdata_i);
      end
      state_d = S_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      region_q    <= RW'(RESET_PAGES);
      fcnt_q      <= FCW'(1);
      lvalid_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      region_q    <= region_d;
      fcnt_q      <= fcnt_d;
      lvalid_q    <= lvalid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q          <= i_d;
    li_q         <= li_d;
    pos_q        <= pos_d;
    slot_q       <= slot_d;
    need_q       <= need_d;
    start_q      <= start_d;
    len_q        <= len_d;
    best_s_q     <= best_s_d;
    best_l_q     <= best_l_d;
    best_i_q     <= best_i_d;
    prev_s_q     <= prev_s_d;
    prev_l_q     <= prev_l_d;
    next_s_q     <= next_s_d;
    next_l_q     <= next_l_d;
    cur_s_q      <= cur_s_d;
    cur_l_q      <= cur_l_d;
    acc_q        <= acc_d;
    status_q     <= status_d;
    user_q       <= user_d;
    rsp_status_q <= rsp_status_d;
    rsp_user_q   <= rsp_user_d;
    rsp_avail_q  <= rsp_avail_d;
  end

  assign rsp.valid           = rsp_valid_q;
  assign rsp.status          = rsp_status_q;
  assign rsp.user_offset     = rsp_user_q;
  assign rsp.available_bytes = rsp_avail_q;

  a_fcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fcnt_q) <= FD)
    else $error("Free table count exceeds its depth.");

  a_cfg_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> state_q == S_INIT)
    else $error("A configuration write did not reload the tables.");

  a_fail_no_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && rsp_valid_d && rsp_status_d != wfra_pkg::STATUS_OK)
      |=> rsp.user_offset == '0)
    else $error("A failed request reported a nonzero user offset.");

  a_grant_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GRANT && l_we) |=> lvalid_q[$past(slot_q)] && user_q[2:0] == 3'd0)
    else $error("A grant left its live entry invalid or its offset misaligned.");

endmodule
